// ===== hw/rtl/res_pkg.sv =====
// Shared types and constants for the repeating event scheduler.
// No dependencies; every other RTL file of the block uses this package.
`default_nettype none

package res_pkg;

  localparam int unsigned SlotsDef = 16;
  localparam int unsigned MaxPlays = 16;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_ADD  = 1'b1;

  typedef struct packed {
    logic        op;
    logic [31:0] now;
    logic [7:0]  map;
    logic [15:0] sound;
    logic [7:0]  noise;
    logic [7:0]  repeat_count;
    logic [7:0]  interval;
    logic [15:0] object_id;
    logic [7:0]  start_delay;
  } in_t;

  typedef struct packed {
    logic [15:0] play_object;
    logic [15:0] play_sound;
    logic [7:0]  play_noise;
    logic        immediate;
    logic        last_play;
  } out_t;

  // One table entry; the active flag lives in flip-flops outside the memory.
  typedef struct packed {
    logic [15:0] sound;
    logic [7:0]  noise;
    logic [7:0]  count;
    logic [31:0] last_time;
    logic [7:0]  interval;
    logic [15:0] object_id;
    logic [7:0]  map;
  } slot_t;

endpackage

`default_nettype wire

// ===== hw/rtl/res_in_if.sv =====
// Input channel of the scheduler: valid/ready handshake with an in_t item.
// Depends on res_pkg.
`default_nettype none

interface res_in_if;
  logic            valid;
  logic            ready;
  res_pkg::in_t    data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/res_out_if.sv =====
// Output channel of the scheduler: valid/ready handshake with an out_t item.
// Depends on res_pkg.
`default_nettype none

interface res_out_if;
  logic            valid;
  logic            ready;
  res_pkg::out_t   data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/repeating_event_scheduler_unit.sv =====
// Repeating event scheduler. An add keeps the input busy after it is accepted while it
// looks for a free slot (one slot flag checked per cycle), plus any output stall. A tick
// keeps it busy while it scans every slot, plus any output stall: the slot table is one
// memory, read once per cycle by a single scan counter unless a play stalls on the
// output. The block takes one item at a time. Reset clears the slot active flags but not
// the slot contents; slot contents are undefined until written and need no clearing pass.
// Depends on res_pkg, res_in_if and res_out_if.
`default_nettype none

module repeating_event_scheduler_unit #(
  parameter int unsigned SLOTS = res_pkg::SlotsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  res_in_if.sink    in_i,
  res_out_if.source out_o
);
  import res_pkg::*;

  localparam int unsigned IdxW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CntW  = $clog2(SLOTS + 1);
  localparam int unsigned PlayW = $clog2(MaxPlays + 1);
  localparam logic [CntW-1:0]  LastIdx  = CntW'(SLOTS - 1);
  localparam logic [CntW-1:0]  SlotsEnd = CntW'(SLOTS);
  localparam logic [PlayW-1:0] PlayMax  = PlayW'(MaxPlays);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ADD   = 2'd1;
  localparam logic [1:0] S_TICK  = 2'd2;
  localparam logic [1:0] S_FLUSH = 2'd3;

  logic [1:0]       state_q, state_d;
  in_t              in_q;
  logic [CntW-1:0]  scan_q, scan_d;
  logic             eval_vld_q, eval_vld_d;
  logic [IdxW-1:0]  eval_idx_q;
  logic [SLOTS-1:0] act_q, act_d;
  out_t             pend_q, pend_d;
  logic             pend_vld_q, pend_vld_d;
  out_t             out_q, out_d;
  logic             out_vld_q, out_vld_d;
  logic [PlayW-1:0] plays_q, plays_d;

  slot_t            mem_q [SLOTS];
  slot_t            rdata_q;
  logic             mem_we;
  logic [IdxW-1:0]  mem_waddr;
  slot_t            mem_wdata;
  logic             rd_en;

  logic             accept, out_free, stall;
  logic [IdxW-1:0]  slot_idx;
  logic             imm;
  logic             ev_act, ev_kill, ev_due, ev_play;
  logic [31:0]      due_time;
  out_t             ev_rec;

  assign accept      = in_i.valid && in_i.ready;
  assign in_i.ready  = (state_q == S_IDLE);
  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_q;
  assign out_free    = !out_vld_q || out_o.ready;
  assign slot_idx    = scan_q[IdxW-1:0];
  assign imm         = (in_q.start_delay == 8'd0);

  // Evaluation of the registered slot read (rdata_q at eval_idx_q)
  assign ev_act   = act_q[eval_idx_q];
  assign ev_kill  = (rdata_q.count == 8'd0) || (rdata_q.map != in_q.map);
  assign due_time = rdata_q.last_time + {24'd0, rdata_q.interval};
  assign ev_due   = (in_q.now >= due_time);
  assign ev_play  = eval_vld_q && ev_act && !ev_kill && ev_due && (plays_q < PlayMax);
  // A new play pushes the held one out, so it waits if the output is occupied
  assign stall    = ev_play && pend_vld_q && !out_free;

  always_comb begin
    ev_rec             = '0;
    ev_rec.play_object = rdata_q.object_id;
    ev_rec.play_sound  = rdata_q.sound;
    ev_rec.play_noise  = rdata_q.noise;
  end

  always_comb begin
    state_d    = state_q;
    scan_d     = scan_q;
    eval_vld_d = eval_vld_q;
    act_d      = act_q;
    pend_d     = pend_q;
    pend_vld_d = pend_vld_q;
    out_d      = out_q;
    out_vld_d  = out_vld_q && !out_o.ready;
    plays_d    = plays_q;
    mem_we     = 1'b0;
    mem_waddr  = slot_idx;
    mem_wdata  = rdata_q;
    rd_en      = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          scan_d     = '0;
          eval_vld_d = 1'b0;
          plays_d    = '0;
          if (in_i.data.op == OP_ADD) begin
            state_d = S_ADD;
            if (in_i.data.start_delay == 8'd0) begin
              pend_d             = '0;
              pend_d.play_sound  = in_i.data.sound;
              pend_d.play_noise  = in_i.data.noise;
              pend_d.immediate   = 1'b1;
              pend_vld_d         = 1'b1;
            end
          end else begin
            state_d = S_TICK;
          end
        end
      end

      S_ADD: begin
        if (!act_q[slot_idx]) begin
          mem_we              = 1'b1;
          mem_wdata.sound     = in_q.sound;
          mem_wdata.noise     = in_q.noise;
          mem_wdata.count     = in_q.repeat_count - {7'd0, imm};
          mem_wdata.last_time = in_q.now;
          mem_wdata.interval  = in_q.interval;
          mem_wdata.object_id = in_q.object_id;
          mem_wdata.map       = in_q.map;
          act_d[slot_idx]     = (in_q.repeat_count > {7'd0, imm});
          state_d             = S_FLUSH;
        end else if (scan_q == LastIdx) begin
          state_d = S_FLUSH;
        end else begin
          scan_d = scan_q + CntW'(1);
        end
      end

      S_TICK: begin
        if (!stall) begin
          if (eval_vld_q) begin
            if (ev_act && ev_kill) begin
              act_d[eval_idx_q] = 1'b0;
            end else if (ev_play) begin
              mem_we              = 1'b1;
              mem_waddr           = eval_idx_q;
              mem_wdata.count     = rdata_q.count - 8'd1;
              mem_wdata.last_time = in_q.now;
              plays_d             = plays_q + PlayW'(1);
              if (pend_vld_q) begin
                out_d     = pend_q;
                out_vld_d = 1'b1;
              end
              pend_d     = ev_rec;
              pend_vld_d = 1'b1;
            end
          end
          rd_en      = (scan_q != SlotsEnd);
          eval_vld_d = rd_en;
          if (rd_en) begin
            scan_d = scan_q + CntW'(1);
          end else if (!eval_vld_q) begin
            state_d = S_FLUSH;
          end
        end
      end

      S_FLUSH: begin
        if (!pend_vld_q) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          out_d           = pend_q;
          out_d.last_play = 1'b1;
          out_vld_d       = 1'b1;
          pend_vld_d      = 1'b0;
          state_d         = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      scan_q     <= '0;
      eval_vld_q <= 1'b0;
      act_q      <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
      plays_q    <= '0;
    end else begin
      state_q    <= state_d;
      scan_q     <= scan_d;
      eval_vld_q <= eval_vld_d;
      act_q      <= act_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
      plays_q    <= plays_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_i.data;
    end
    if (rd_en) begin
      eval_idx_q <= slot_idx;
    end
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  // Slot table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rdata_q <= mem_q[slot_idx];
    end
  end

  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !pend_vld_q && !eval_vld_q)
    else $error("held play or slot evaluation left over in idle");

  a_play_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    plays_q <= PlayMax)
    else $error("tick play count beyond limit");

  a_eval_in_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eval_vld_q |-> state_q == S_TICK)
    else $error("slot evaluation outside a tick scan");

  a_imm_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_i.data.op == OP_ADD && in_i.data.start_delay == 8'd0
    |=> pend_vld_q && pend_q.immediate)
    else $error("immediate play not held after add");

  a_imm_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.immediate |-> out_q.last_play)
    else $error("immediate play not marked as last item");

endmodule

`default_nettype wire
